// ----- rtl/adi_pkg.sv -----
// ----------------------------------------------------------------------------
// adi_pkg
// widths, command and register codes and shared types for the audio dma block
// ----------------------------------------------------------------------------
package adi_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 24;
    localparam int LEN_W     = 18;
    localparam int LOW_W     = 13;
    localparam int HIGH_W    = ADDR_W - LOW_W;
    localparam int ACC_W     = 27;
    localparam int ELAPSED_W = 5;
    localparam int CMD_W     = 2;
    localparam int REG_W     = 3;
    localparam int ALIGN_W   = 3;

    localparam logic [ACC_W-1:0] PERIOD_RESET = ACC_W'(2126);
    localparam logic [LOW_W-1:0] WORD_STEP    = LOW_W'(4);
    localparam logic [LEN_W-1:0] LEN_STEP     = LEN_W'(4);

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [REG_W-1:0] REG_ADDRESS  = 3'd0;
    localparam logic [REG_W-1:0] REG_LENGTH   = 3'd1;
    localparam logic [REG_W-1:0] REG_CONTROL  = 3'd2;
    localparam logic [REG_W-1:0] REG_STATUS   = 3'd3;
    localparam logic [REG_W-1:0] REG_DAC_RATE = 3'd4;
    localparam logic [REG_W-1:0] REG_BIT_RATE = 3'd5;

    // status word bits
    localparam int STAT_FULL_LO = 0;
    localparam int STAT_ONE_A   = 20;
    localparam int STAT_ONE_B   = 24;
    localparam int STAT_BUSY    = 30;
    localparam int STAT_FULL_HI = 31;

    typedef struct packed {
        logic              addr_wr;
        logic              len_wr;
        logic              irq_clr;
        logic              emit;
        logic [DATA_W-1:0] wdata;
    } t_queue_ctrl;

    typedef struct packed {
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_address;
        logic [LEN_W-1:0]  head_length;
        logic              full;
        logic              busy;
        logic              irq;
    } t_queue_stat;

endpackage

// ----- rtl/adi_in_if.sv -----
// ----------------------------------------------------------------------------
// adi_in_if
// request channel: command, register index, write data and elapsed cycles
// ----------------------------------------------------------------------------
interface adi_in_if
    import adi_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [REG_W-1:0]     reg_index;
    logic [DATA_W-1:0]    write_data;
    logic [ELAPSED_W-1:0] elapsed_cycles;

    modport source (
        output valid, cmd, reg_index, write_data, elapsed_cycles,
        input  ready
    );

    modport sink (
        input  valid, cmd, reg_index, write_data, elapsed_cycles,
        output ready
    );
endinterface

// ----- rtl/adi_out_if.sv -----
// ----------------------------------------------------------------------------
// adi_out_if
// result channel: read data, access error, sample fetch and interrupt level
// ----------------------------------------------------------------------------
interface adi_out_if
    import adi_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bad_access;
    logic              sample_due;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_address;
    logic              irq_level;

    modport source (
        output valid, read_data, bad_access, sample_due, fetch_valid,
               fetch_address, irq_level,
        input  ready
    );

    modport sink (
        input  valid, read_data, bad_access, sample_due, fetch_valid,
               fetch_address, irq_level,
        output ready
    );
endinterface

// ----- rtl/adi_sample_timer.sv -----
// ----------------------------------------------------------------------------
// adi_sample_timer
// saturating cycle accumulator that flags one sample per tick past the period
// ----------------------------------------------------------------------------
module adi_sample_timer
    import adi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    input  logic [ACC_W-1:0]     i_period,
    output logic                 o_due
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sat;
    logic             past;

    always_comb begin
        sum   = {1'b0, r_acc} + (ACC_W + 1)'(i_elapsed);
        sat   = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        past  = sat > i_period;
        n_acc = past ? sat - i_period : sat;
        o_due = i_tick && past;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_tick) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- rtl/adi_buffer_queue.sv -----
// ----------------------------------------------------------------------------
// adi_buffer_queue
// buffer address and length queue, fetch address stepping and interrupt flag
// ----------------------------------------------------------------------------
module adi_buffer_queue
    import adi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_ctrl i_ctrl,
    output t_queue_stat o_stat
);

    logic [ADDR_W-1:0] r_addr [QUEUE_DEPTH];
    logic [ADDR_W-1:0] n_addr [QUEUE_DEPTH];
    logic [LEN_W-1:0]  r_len  [QUEUE_DEPTH];
    logic [LEN_W-1:0]  n_len  [QUEUE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_carry;
    logic              n_carry;
    logic              r_irq;
    logic              n_irq;

    logic              full;
    logic              busy;
    logic              fetch;
    logic [HIGH_W-1:0] hi;
    logic [LOW_W-1:0]  lo;
    logic [ADDR_W-1:0] fetch_addr;
    logic [LEN_W-1:0]  len_dec;
    logic [LEN_W-1:0]  wr_len;
    logic [ADDR_W-1:0] wr_addr;
    logic [IDX_W-1:0]  tail;

    always_comb begin
        full       = r_count == CNT_W'(QUEUE_DEPTH);
        busy       = r_count != '0;
        fetch      = i_ctrl.emit && busy;
        tail       = r_count[IDX_W-1:0];
        hi         = r_addr[0][ADDR_W-1:LOW_W] + HIGH_W'(r_carry);
        lo         = r_addr[0][LOW_W-1:0] + WORD_STEP;
        fetch_addr = {hi, r_addr[0][LOW_W-1:0]};
        len_dec    = r_len[0] - LEN_STEP;
        wr_len     = {i_ctrl.wdata[LEN_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
        wr_addr    = {i_ctrl.wdata[ADDR_W-1:ALIGN_W], {ALIGN_W{1'b0}}};

        n_addr  = r_addr;
        n_len   = r_len;
        n_count = r_count;
        n_carry = r_carry;
        n_irq   = r_irq;

        if (i_ctrl.addr_wr && !full) begin
            n_addr[tail] = wr_addr;
        end
        if (i_ctrl.len_wr && !full && wr_len != '0) begin
            n_len[tail] = wr_len;
            n_count     = r_count + CNT_W'(1);
        end
        if (i_ctrl.irq_clr) begin
            n_irq = 1'b0;
        end
        if (fetch) begin
            n_addr[0] = {hi, lo};
            n_carry   = lo == '0;
            n_len[0]  = len_dec;
            if (len_dec == '0) begin
                n_irq   = 1'b1;
                n_count = r_count - CNT_W'(1);
                // advance to the next queued buffer
                if (r_count > CNT_W'(1)) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_addr[i] = r_addr[i+1];
                        n_len[i]  = r_len[i+1];
                    end
                end
            end
        end

        o_stat.fetch_valid   = fetch;
        o_stat.fetch_address = fetch ? fetch_addr : '0;
        o_stat.head_length   = r_len[0];
        o_stat.full          = full;
        o_stat.busy          = busy;
        o_stat.irq           = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_addr[i] <= '0;
                r_len[i]  <= '0;
            end
            r_count <= '0;
            r_carry <= 1'b0;
            r_irq   <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_count <= n_count;
            r_carry <= n_carry;
            r_irq   <= n_irq;
        end
    end

endmodule

// ----- rtl/audio_dma_interface_core.sv -----
// ----------------------------------------------------------------------------
// audio_dma_interface_core
// audio dma register interface with buffer queue and sample fetch timing
//
//   channel    role    carries
//   i_in_ch    sink    cmd, reg_index, write_data, elapsed_cycles
//   o_out_ch   source  read_data, bad_access, sample_due, fetch_valid,
//                      fetch_address, irq_level
//   i_cfg_*    write   sample_period
//
// each transaction passes an input register and a result register, one
// transaction per cycle sustained while the result channel is not stalled
// the state update sits between the two registers
// a stalled result register holds a full input stage; the input stage
// takes a transaction whenever it is empty or advances in the same cycle
// synchronous active-low reset clears the queue, accumulator and flags
// ----------------------------------------------------------------------------
module audio_dma_interface_core
    import adi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    adi_in_if.sink            i_in_ch,
    adi_out_if.source         o_out_ch,
    input  logic              i_cfg_we,
    input  logic [ACC_W-1:0]  i_cfg_wdata
);

    logic [ACC_W-1:0]     r_period;

    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_cmd;
    logic [REG_W-1:0]     r_reg;
    logic [DATA_W-1:0]    r_wdata;
    logic [ELAPSED_W-1:0] r_elapsed;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_read_data;
    logic                 r_bad;
    logic                 r_due;
    logic                 r_fetch_valid;
    logic [ADDR_W-1:0]    r_fetch_addr;
    logic                 r_irq;

    logic                 advance;
    logic                 fire;
    logic                 tick;
    logic                 due;
    logic [DATA_W-1:0]    n_read_data;
    logic                 n_bad;
    t_queue_ctrl          ctrl;
    t_queue_stat          stat;

    assign advance        = !r_out_valid || o_out_ch.ready;
    assign fire           = r_in_valid && advance;
    assign i_in_ch.ready  = !r_in_valid || advance;
    assign tick           = fire && r_cmd == CMD_TICK;

    always_comb begin
        ctrl.addr_wr = 1'b0;
        ctrl.len_wr  = 1'b0;
        ctrl.irq_clr = 1'b0;
        ctrl.emit    = due;
        ctrl.wdata   = r_wdata;
        n_read_data  = '0;
        n_bad        = 1'b0;
        case (r_cmd)
            CMD_TICK: begin
                n_bad = 1'b0;
            end
            CMD_WRITE: begin
                case (r_reg)
                    REG_ADDRESS:  ctrl.addr_wr = fire;
                    REG_LENGTH:   ctrl.len_wr  = fire;
                    REG_STATUS:   ctrl.irq_clr = fire;
                    REG_CONTROL,
                    REG_DAC_RATE,
                    REG_BIT_RATE: n_bad = 1'b0;
                    default:      n_bad = 1'b1;
                endcase
            end
            CMD_READ: begin
                case (r_reg)
                    REG_LENGTH: begin
                        n_read_data = DATA_W'(stat.head_length);
                    end
                    REG_STATUS: begin
                        n_read_data[STAT_FULL_LO] = stat.full;
                        n_read_data[STAT_ONE_A]   = 1'b1;
                        n_read_data[STAT_ONE_B]   = 1'b1;
                        n_read_data[STAT_BUSY]    = stat.busy;
                        n_read_data[STAT_FULL_HI] = stat.full;
                    end
                    default: n_bad = 1'b1;
                endcase
            end
            default: n_bad = 1'b1;
        endcase
    end

    adi_sample_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_elapsed (r_elapsed),
        .i_period  (r_period),
        .o_due     (due)
    );

    adi_buffer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_cmd     <= i_in_ch.cmd;
            r_reg     <= i_in_ch.reg_index;
            r_wdata   <= i_in_ch.write_data;
            r_elapsed <= i_in_ch.elapsed_cycles;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data   <= n_read_data;
            r_bad         <= n_bad;
            r_due         <= due;
            r_fetch_valid <= stat.fetch_valid;
            r_fetch_addr  <= stat.fetch_address;
            r_irq         <= stat.irq;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.read_data     = r_read_data;
    assign o_out_ch.bad_access    = r_bad;
    assign o_out_ch.sample_due    = r_due;
    assign o_out_ch.fetch_valid   = r_fetch_valid;
    assign o_out_ch.fetch_address = r_fetch_addr;
    assign o_out_ch.irq_level     = r_irq;

endmodule
